// ----- src/p3cs_pkg.sv -----
package p3cs_pkg;

    // Cell geometry
    localparam int unsigned CELL_BITS = 3;

    // Grid size limits applied to the size registers
    localparam int unsigned MAX_ROWS = 16;
    localparam int unsigned MAX_COLS = 16;

    // Default memory size in bytes
    localparam int unsigned MEM_BYTES_DEF = 128;

    // Widths of the position arithmetic: cell index, bit position, byte address
    localparam int unsigned IDX_W  = 9;
    localparam int unsigned POS_W  = 12;
    localparam int unsigned BYTE_W = POS_W - 3;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD  = 2'd2;

    // Operation codes; the unused code behaves as a read
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] row;
        logic [3:0] column;
        logic [2:0] cell_value;
    } in_t;

    typedef struct packed {
        logic [2:0] cell_out;
        logic       out_of_range;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_BUSY  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

endpackage

// ----- src/p3cs_ram.sv -----
module p3cs_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/packed_3bit_cell_store.sv -----
// Packed 3-bit cell store.
// A grid of 3-bit cells lives in a byte memory, packed MSB-first after a
// programmable number of pad bits. Each beat on the s_ channel reads, writes
// or clears one cell; each produces exactly one beat on the m_ channel with
// the cell value and an out-of-range flag (no write happens when it is set).
// Size and pad registers are to be written through the cfg_ port while idle.
// Bytes are split across an even bank and an odd bank, so a cell that
// straddles two bytes is read and written back in one access of each bank.
// The bytes are read when the input beat is taken; in the write-back
// cycle the result goes to the output register if free, else is parked.
// A new item is taken only after the previous item's bytes are written
// back; s_ready drops during the write cycle. After reset the banks are
// zeroed by a clearing pass over all entries; s_ready stays low meanwhile,
// but configuration writes are taken, as the block does not itself enforce
// the idle rule above. When the receiver stalls, the result waits in the
// output register; a further beat may still be taken, and its result is
// parked internally until the output register frees, holding s_ready low.
module packed_3bit_cell_store import p3cs_pkg::*; #(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_payload
);

    localparam int unsigned DEPTH_E  = (MEM_BYTES + 1) / 2;
    localparam int unsigned DEPTH_O  = MEM_BYTES / 2;
    localparam int unsigned AW       = (DEPTH_E > 1) ? $clog2(DEPTH_E) : 1;
    localparam int unsigned MEM_BITS = MEM_BYTES * 8;

    state_t          st_reg;
    logic [AW-1:0]   clr_reg;
    logic [4:0]      cols_reg;
    logic [4:0]      rows_reg;
    logic [2:0]      pad_reg;
    logic            m_valid_reg;
    out_t            m_payload_reg;
    out_t            hold_reg;

    // Item registers
    logic [1:0]      op_reg;
    logic [2:0]      val_reg;
    logic            bad_reg;
    logic [2:0]      off_reg;
    logic            swap_reg;
    logic [AW-1:0]   ia_e_reg;
    logic [AW-1:0]   ia_o_reg;

    logic            accept;
    logic [4:0]      cols_eff;
    logic [4:0]      rows_eff;
    logic [IDX_W-1:0]  cell_idx;
    logic [POS_W-1:0]  pos;
    logic [31:0]     end_bit;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b0_half;
    logic            bad_next;

    logic            we_e, we_o;
    logic [AW-1:0]   wa_e, wa_o;
    logic [7:0]      wd_e, wd_o;
    logic [AW-1:0]   ra_e, ra_o;
    logic [7:0]      rd_e, rd_o;

    logic [15:0]     window;
    logic [15:0]     window_new;
    logic [3:0]      sh;
    logic [2:0]      cell_rd;
    logic [2:0]      wv;
    logic            is_wr;
    logic            we_hi, we_lo;
    out_t            res;
    logic            out_free;
    logic            load_out;
    out_t            out_next;

    assign s_ready   = (st_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Decode the cell position of the incoming beat
    always_comb begin
        cols_eff = (32'(cols_reg) > MAX_COLS) ? 5'(MAX_COLS) : cols_reg;
        rows_eff = (32'(rows_reg) > MAX_ROWS) ? 5'(MAX_ROWS) : rows_reg;
        cell_idx = IDX_W'(s_payload.row) * IDX_W'(cols_eff) + IDX_W'(s_payload.column);
        pos      = POS_W'(pad_reg) + (POS_W'(cell_idx) << 1) + POS_W'(cell_idx);
        end_bit  = 32'(pos) + 32'(CELL_BITS);
        bad_next = (5'(s_payload.row) >= rows_eff) || (5'(s_payload.column) >= cols_eff) ||
                   (end_bit > MEM_BITS);
        b0       = pos[POS_W-1:3];
        b0_half  = b0 >> 1;
        // Byte b0 sits in the odd bank when b0 is odd; its neighbor then
        // is the next even entry
        ra_o     = AW'(b0_half);
        ra_e     = b0[0] ? AW'(b0_half + BYTE_W'(1)) : AW'(b0_half);
    end

    // Capture the item at acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_payload.operation;
            val_reg  <= s_payload.cell_value;
            bad_reg  <= bad_next;
            off_reg  <= pos[2:0];
            swap_reg <= b0[0];
            ia_e_reg <= ra_e;
            ia_o_reg <= ra_o;
        end
    end

    // Modify the two-byte window around the cell
    always_comb begin
        window     = swap_reg ? {rd_o, rd_e} : {rd_e, rd_o};
        sh         = 4'd13 - 4'(off_reg);
        cell_rd    = 3'(window >> sh);
        is_wr      = (op_reg == OP_WRITE) || (op_reg == OP_CLEAR);
        wv         = (op_reg == OP_WRITE) ? val_reg : 3'd0;
        window_new = (window & ~(16'h0007 << sh)) | (16'(wv) << sh);
        we_hi      = (st_reg == ST_BUSY) && is_wr && !bad_reg;
        we_lo      = we_hi && (off_reg > 3'd5);
        res.out_of_range = bad_reg;
        res.cell_out     = bad_reg ? 3'd0 : (is_wr ? wv : cell_rd);
    end

    // Select the bank write ports: clearing pass or write-back
    always_comb begin
        we_e = 1'b0;
        we_o = 1'b0;
        wa_e = ia_e_reg;
        wa_o = ia_o_reg;
        wd_e = swap_reg ? window_new[7:0] : window_new[15:8];
        wd_o = swap_reg ? window_new[15:8] : window_new[7:0];
        if (st_reg == ST_CLEAR) begin
            we_e = 1'b1;
            we_o = (32'(clr_reg) < DEPTH_O);
            wa_e = clr_reg;
            wa_o = clr_reg;
            wd_e = 8'd0;
            wd_o = 8'd0;
        end else begin
            we_e = swap_reg ? we_lo : we_hi;
            we_o = swap_reg ? we_hi : we_lo;
        end
    end

    p3cs_ram #(
        .DEPTH (DEPTH_E),
        .AW    (AW)
    ) u_bank_even (
        .aclk  (aclk),
        .we    (we_e),
        .waddr (wa_e),
        .wdata (wd_e),
        .re    (accept),
        .raddr (ra_e),
        .rdata (rd_e)
    );

    p3cs_ram #(
        .DEPTH (DEPTH_O),
        .AW    (AW)
    ) u_bank_odd (
        .aclk  (aclk),
        .we    (we_o),
        .waddr (wa_o),
        .wdata (wd_o),
        .re    (accept),
        .raddr (ra_o),
        .rdata (rd_o)
    );

    // Pick what goes to the output register
    always_comb begin
        load_out = 1'b0;
        out_next = res;
        unique case (st_reg)
            ST_BUSY: load_out = out_free;
            ST_HOLD: begin
                load_out = out_free;
                out_next = hold_reg;
            end
            ST_CLEAR, ST_IDLE: load_out = 1'b0;
            default: load_out = 1'b0;
        endcase
    end

    // Control state, configuration and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLEAR;
            clr_reg     <= '0;
            cols_reg    <= 5'd16;
            rows_reg    <= 5'd16;
            pad_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_COLS: cols_reg <= cfg_wr_data;
                    REG_ROWS: rows_reg <= cfg_wr_data;
                    REG_PAD:  pad_reg  <= cfg_wr_data[2:0];
                    default:  ;
                endcase
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (st_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH_E - 1)) begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        st_reg <= ST_BUSY;
                    end
                end
                ST_BUSY: st_reg <= out_free ? ST_IDLE : ST_HOLD;
                ST_HOLD: begin
                    if (out_free) begin
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // Output and parked result payloads
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_payload_reg <= out_next;
        end
        if (st_reg == ST_BUSY && !out_free) begin
            hold_reg <= res;
        end
    end

    // The write cycle never repeats back to back
    a_busy_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_BUSY |=> st_reg != ST_BUSY)
        else $error("write-back cycle repeated");

    // A taken beat moves straight to the write-back cycle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st_reg == ST_BUSY)
        else $error("accepted beat not processed");

    // Nothing is written for an out-of-range cell
    a_no_bad_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_BUSY && bad_reg) |-> (!we_e && !we_o))
        else $error("write for out-of-range cell");

    // A parked result only exists while the output register is full
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_HOLD |-> m_valid_reg)
        else $error("result parked with empty output");

    // Out-of-range results carry a zero value
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.out_of_range) |-> (m_payload_reg.cell_out == 3'd0))
        else $error("out-of-range result with nonzero value");

endmodule

// ----- tb/sv/tb_packed_3bit_cell_store.sv -----
module tb_packed_3bit_cell_store import p3cs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BOARD_BYTES = MEM_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_payload;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_payload;

    // Shadow copy of the cell memory and the size registers
    logic [7:0] board_mem [BOARD_BYTES];
    logic [4:0] cols_reg;
    logic [4:0] rows_reg;
    logic [2:0] pad_reg;

    out_t cell_results_q[$];
    int   errors;
    int   cycles;
    bit   gaps_on;
    bit   stalls_on;
    int   stall_left;
    int   hold_off_left;

    packed_3bit_cell_store i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Bound the run length
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Compute the result of one cell access and apply it to the shadow memory
    function automatic out_t predict_cell(input in_t beat);
        int unsigned eff_cols;
        int unsigned eff_rows;
        int unsigned pos;
        int unsigned p;
        logic [2:0]  wr_val;
        logic        bad;
        out_t        res;
        eff_cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        eff_rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        pos = pad_reg + (beat.row * eff_cols + beat.column) * CELL_BITS;
        bad = (beat.row >= eff_rows) || (beat.column >= eff_cols) ||
              (pos + CELL_BITS > BOARD_BYTES * 8);
        res.cell_out = 3'd0;
        res.out_of_range = bad;
        if (!bad) begin
            if (beat.operation == OP_WRITE || beat.operation == OP_CLEAR) begin
                wr_val = (beat.operation == OP_WRITE) ? beat.cell_value : 3'd0;
                for (int i = 0; i < CELL_BITS; i++) begin
                    p = pos + i;
                    board_mem[p >> 3][7 - (p & 7)] = wr_val[CELL_BITS - 1 - i];
                end
                res.cell_out = wr_val;
            end else begin
                // Read, including the spare operation code
                for (int i = 0; i < CELL_BITS; i++) begin
                    p = pos + i;
                    res.cell_out[CELL_BITS - 1 - i] = board_mem[p >> 3][7 - (p & 7)];
                end
            end
        end
        return res;
    endfunction

    function automatic in_t cell_beat(input logic [1:0] op, input logic [3:0] row,
                                      input logic [3:0] col, input logic [2:0] val);
        in_t beat;
        beat.operation = op;
        beat.row = row;
        beat.column = col;
        beat.cell_value = val;
        return beat;
    endfunction

    // Mostly in-grid accesses with random content, the rest anywhere
    function automatic in_t random_cell();
        int unsigned eff_cols;
        int unsigned eff_rows;
        int unsigned r;
        in_t         beat;
        eff_cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        eff_rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        r = $urandom_range(0, 99);
        if (r < 40)
            beat.operation = OP_READ;
        else if (r < 75)
            beat.operation = OP_WRITE;
        else if (r < 90)
            beat.operation = OP_CLEAR;
        else
            beat.operation = OP_SPARE;
        if ($urandom_range(0, 99) < 85 && eff_cols > 0 && eff_rows > 0) begin
            beat.row = 4'($urandom_range(0, eff_rows - 1));
            beat.column = 4'($urandom_range(0, eff_cols - 1));
        end else begin
            beat.row = 4'($urandom_range(0, 15));
            beat.column = 4'($urandom_range(0, 15));
        end
        beat.cell_value = 3'($urandom_range(0, 7));
        return beat;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drive m_ready: hold-off first, then random stalls
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    // Compare each result beat with the oldest expected one
    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cell_results_q.size() == 0) begin
                $display("%0t: unexpected beat cell_out=%0d out_of_range=%0b",
                         $time, m_payload.cell_out, m_payload.out_of_range);
                errors++;
            end else begin
                want = cell_results_q.pop_front();
                if (m_payload.cell_out !== want.cell_out) begin
                    $display("%0t: cell_out mismatch expected %0d actual %0d",
                             $time, want.cell_out, m_payload.cell_out);
                    errors++;
                end
                if (m_payload.out_of_range !== want.out_of_range) begin
                    $display("%0t: out_of_range mismatch expected %0b actual %0b",
                             $time, want.out_of_range, m_payload.out_of_range);
                    errors++;
                end
            end
        end
    end

    // Offer one beat after an idle gap and hold it until taken
    task automatic send_cell(input in_t beat, input int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_payload <= beat;
        do @(posedge aclk); while (!s_ready);
        cell_results_q.push_back(predict_cell(beat));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            REG_COLS: cols_reg = data;
            REG_ROWS: rows_reg = data;
            REG_PAD:  pad_reg = data[2:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_grid(input logic [4:0] cols, input logic [4:0] rows,
                            input logic [2:0] pad);
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        // Upper data bits are don't-care for the pad register
        write_reg(REG_PAD, {2'($urandom_range(0, 3)), pad});
    endtask

    // Drop valid and wait until every expected beat has drained
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (cell_results_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [4:0] cols, input logic [4:0] rows,
                             input logic [2:0] pad, input int n_items,
                             input bit gaps, input bit stalls);
        drain();
        set_grid(cols, rows, pad);
        gaps_on = gaps;
        stalls_on = stalls;
        repeat (n_items) send_cell(random_cell(), pick_gap());
    endtask

    // Default grid: extremes, every operation, straddling cells
    task automatic test_directed_basic();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_cell(cell_beat(OP_READ, 4'd0, 4'd0, 3'd7), 0);
        send_cell(cell_beat(OP_WRITE, 4'd0, 4'd0, 3'd7), 0);
        send_cell(cell_beat(OP_WRITE, 4'd15, 4'd15, 3'd5), 0);
        send_cell(cell_beat(OP_READ, 4'd15, 4'd15, 3'd0), 0);
        send_cell(cell_beat(OP_SPARE, 4'd0, 4'd0, 3'd0), 0);
        send_cell(cell_beat(OP_CLEAR, 4'd0, 4'd0, 3'd7), 0);
        send_cell(cell_beat(OP_WRITE, 4'd0, 4'd2, 3'd7), 0);
        send_cell(cell_beat(OP_READ, 4'd0, 4'd2, 3'd0), 0);
    endtask

    // Pad, out-of-range, oversized and zero sizes, unused register index
    task automatic test_directed_config();
        drain();
        set_grid(5'd16, 5'd16, 3'd7);
        send_cell(cell_beat(OP_WRITE, 4'd0, 4'd0, 3'd6), 0);
        send_cell(cell_beat(OP_READ, 4'd0, 4'd0, 3'd0), 0);
        send_cell(cell_beat(OP_READ, 4'd15, 4'd15, 3'd0), 0);
        drain();
        set_grid(5'd5, 5'd3, 3'd0);
        send_cell(cell_beat(OP_WRITE, 4'd2, 4'd4, 3'd3), 0);
        send_cell(cell_beat(OP_WRITE, 4'd3, 4'd0, 3'd7), 0);
        send_cell(cell_beat(OP_READ, 4'd0, 4'd5, 3'd0), 0);
        send_cell(cell_beat(OP_WRITE, 4'd15, 4'd15, 3'd7), 0);
        drain();
        set_grid(5'd31, 5'd17, 3'd0);
        send_cell(cell_beat(OP_WRITE, 4'd15, 4'd15, 3'd1), 0);
        send_cell(cell_beat(OP_READ, 4'd15, 4'd15, 3'd0), 0);
        drain();
        set_grid(5'd0, 5'd16, 3'd0);
        send_cell(cell_beat(OP_READ, 4'd0, 4'd0, 3'd0), 0);
        drain();
        set_grid(5'd16, 5'd0, 3'd0);
        send_cell(cell_beat(OP_WRITE, 4'd0, 4'd0, 3'd2), 0);
        drain();
        set_grid(5'd16, 5'd16, 3'd0);
        write_reg(REG_UNUSED, 5'h1f);
        send_cell(cell_beat(OP_READ, 4'd0, 4'd0, 3'd0), 0);
        send_cell(cell_beat(OP_READ, 4'd2, 4'd4, 3'd0), 0);
    endtask

    task automatic test_random_sweep();
        logic [4:0] cols;
        logic [4:0] rows;
        run_phase(5'd16, 5'd16, 3'd0, 300, 1'b1, 1'b1);
        run_phase(5'd1, 5'd1, 3'd7, 100, 1'b1, 1'b1);
        // Back-to-back stretch with no idling on either side
        run_phase(5'd16, 5'd16, 3'd3, 300, 1'b0, 1'b0);
        repeat (4) begin
            cols = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
            rows = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
            run_phase(cols, rows, 3'($urandom_range(0, 7)), 150, 1'b1, 1'b1);
        end
        run_phase(5'd31, 5'd31, 3'd5, 250, 1'b1, 1'b1);
    endtask

    // Hold off the result side long enough that the block fills and stalls input
    task automatic test_backpressure();
        drain();
        set_grid(5'd16, 5'd16, 3'd2);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        hold_off_left = 300;
        repeat (100) send_cell(random_cell(), 0);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_COLS;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_payload = '0;
        errors = 0;
        cycles = 0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        stall_left = 0;
        hold_off_left = 0;
        foreach (board_mem[i])
            board_mem[i] = 8'h00;
        cols_reg = 5'd16;
        rows_reg = 5'd16;
        pad_reg = 3'd0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_basic();
        test_directed_config();
        test_random_sweep();
        test_backpressure();

        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
